// ===== design/polyline_farthest_point_split_unit_defines.svh =====
// Assertion macros shared by the farthest point split unit modules.
// Depends on nothing; users must have clk and arst_n in scope.
`ifndef POLYLINE_FARTHEST_POINT_SPLIT_UNIT_DEFINES_SVH
`define POLYLINE_FARTHEST_POINT_SPLIT_UNIT_DEFINES_SVH

// Checks a property on every rising clock edge outside of reset.
`define PFPS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checks a property on every rising clock edge, reset included.
`define PFPS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== design/pfps_pkg.sv =====
// Shared types and constants of the farthest point split unit.
// Depends on nothing; imported by the controller, datapath and top level.
package pfps_pkg;

	localparam int COORD_W = 12;
	localparam int INDEX_W = 10;

	localparam logic [1:0] RD_A    = 2'd0;
	localparam logic [1:0] RD_B    = 2'd1;
	localparam logic [1:0] RD_SCAN = 2'd2;
	localparam logic [1:0] RD_OUT  = 2'd3;

	typedef struct packed {
		logic [COORD_W-1:0] point_x;
		logic [COORD_W-1:0] point_y;
		logic               last_point;
	} point_t;

	typedef struct packed {
		logic [COORD_W-1:0] vertex_x;
		logic [COORD_W-1:0] vertex_y;
		logic [INDEX_W-1:0] vertex_index;
		logic               last_vertex;
	} vertex_t;

	typedef struct packed {
		logic       pt_write;
		logic       cnt_clear;
		logic       kept_wr_end;
		logic       kept_wr_zero;
		logic       kept_wr_split;
		logic       a_clear;
		logic       a_from_b;
		logic       b_load;
		logic       best_init;
		logic       latch_a;
		logic       latch_d;
		logic       scan_issue;
		logic       out_load;
		logic       out_last;
		logic [1:0] rd_sel;
	} cmd_t;

	typedef struct packed {
		logic seg_empty;
		logic scan_last;
		logic pipe_busy;
		logic out_taken;
	} sts_t;

endpackage

// ===== design/pfps_ctrl.sv =====
// Controller state machine of the farthest point split unit.
// Depends on pfps_pkg and the assertion macro header.
`include "polyline_farthest_point_split_unit_defines.svh"

module pfps_ctrl #(
	parameter int LEVELS = 4,
	parameter int SW     = 5
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            point_valid,
	input  logic            last_point,
	output logic            point_stall,
	output pfps_pkg::cmd_t  cmd,
	output logic [SW-1:0]   kept_addr,
	input  pfps_pkg::sts_t  sts
);
	import pfps_pkg::*;

	localparam int KEPT = (1 << LEVELS) + 1;
	localparam int LVW  = $clog2(LEVELS + 1);
	localparam logic [SW-1:0] LAST_SLOT = SW'(KEPT - 1);

	localparam logic [3:0] S_LOAD  = 4'd0;
	localparam logic [3:0] S_INIT0 = 4'd1;
	localparam logic [3:0] S_INIT1 = 4'd2;
	localparam logic [3:0] S_LVL   = 4'd3;
	localparam logic [3:0] S_RK    = 4'd4;
	localparam logic [3:0] S_RB    = 4'd5;
	localparam logic [3:0] S_RA    = 4'd6;
	localparam logic [3:0] S_RDB   = 4'd7;
	localparam logic [3:0] S_RD    = 4'd8;
	localparam logic [3:0] S_SCAN  = 4'd9;
	localparam logic [3:0] S_DRAIN = 4'd10;
	localparam logic [3:0] S_WR    = 4'd11;
	localparam logic [3:0] S_ORK   = 4'd12;
	localparam logic [3:0] S_ORS   = 4'd13;
	localparam logic [3:0] S_OLD   = 4'd14;
	localparam logic [3:0] S_OWT   = 4'd15;

	logic [3:0]     state_q, state_d;
	logic [LVW-1:0] lvl_q;
	logic [SW-1:0]  j_q;
	logic [SW-1:0]  o_q;
	logic [LVW-1:0] shift;
	logic [SW-1:0]  j_inc;
	logic [SW-1:0]  b_slot;
	logic [SW-1:0]  mid_slot;
	logic [SW-1:0]  last_j;
	logic           last_pair;
	logic           last_level;

	assign shift      = LVW'(LEVELS) - lvl_q;
	assign j_inc      = j_q + SW'(1);
	assign b_slot     = j_inc << shift;
	assign mid_slot   = (j_q << shift) + (SW'(1) << (shift - LVW'(1)));
	assign last_j     = (SW'(1) << lvl_q) - SW'(1);
	assign last_pair  = (j_q == last_j);
	assign last_level = (lvl_q == LVW'(LEVELS - 1));

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.rd_sel  = RD_A;
		point_stall = 1'b1;
		kept_addr   = '0;
		unique case (state_q)
			S_LOAD: begin
				point_stall  = 1'b0;
				cmd.pt_write = point_valid;
				if (point_valid && last_point) begin
					state_d = S_INIT0;
				end
			end
			S_INIT0: begin
				kept_addr       = LAST_SLOT;
				cmd.kept_wr_end = 1'b1;
				state_d         = S_INIT1;
			end
			S_INIT1: begin
				kept_addr        = '0;
				cmd.kept_wr_zero = 1'b1;
				state_d          = S_LVL;
			end
			S_LVL: begin
				cmd.a_clear = 1'b1;
				state_d     = S_RK;
			end
			S_RK: begin
				kept_addr = b_slot;
				state_d   = S_RB;
			end
			S_RB: begin
				kept_addr  = b_slot;
				cmd.b_load = 1'b1;
				state_d    = S_RA;
			end
			S_RA: begin
				cmd.rd_sel    = RD_A;
				cmd.best_init = 1'b1;
				state_d       = sts.seg_empty ? S_WR : S_RDB;
			end
			S_RDB: begin
				cmd.rd_sel  = RD_B;
				cmd.latch_a = 1'b1;
				state_d     = S_RD;
			end
			S_RD: begin
				cmd.latch_d = 1'b1;
				state_d     = S_SCAN;
			end
			S_SCAN: begin
				cmd.rd_sel     = RD_SCAN;
				cmd.scan_issue = 1'b1;
				if (sts.scan_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				if (!sts.pipe_busy) begin
					state_d = S_WR;
				end
			end
			S_WR: begin
				kept_addr         = mid_slot;
				cmd.kept_wr_split = 1'b1;
				cmd.a_from_b      = 1'b1;
				if (!last_pair) begin
					state_d = S_RK;
				end else if (last_level) begin
					state_d = S_ORK;
				end else begin
					state_d = S_LVL;
				end
			end
			S_ORK: begin
				kept_addr = o_q;
				state_d   = S_ORS;
			end
			S_ORS: begin
				kept_addr  = o_q;
				cmd.rd_sel = RD_OUT;
				state_d    = S_OLD;
			end
			S_OLD: begin
				kept_addr    = o_q;
				cmd.out_load = 1'b1;
				cmd.out_last = (o_q == LAST_SLOT);
				state_d      = S_OWT;
			end
			S_OWT: begin
				kept_addr = o_q;
				if (sts.out_taken) begin
					if (o_q == LAST_SLOT) begin
						cmd.cnt_clear = 1'b1;
						state_d       = S_LOAD;
					end else begin
						state_d = S_ORK;
					end
				end
			end
			default: begin
				state_d = S_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			lvl_q   <= '0;
			j_q     <= '0;
			o_q     <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_INIT1) begin
				lvl_q <= '0;
			end
			if (state_q == S_LVL) begin
				j_q <= '0;
			end
			if (state_q == S_WR) begin
				if (!last_pair) begin
					j_q <= j_inc;
				end else if (last_level) begin
					o_q <= '0;
				end else begin
					lvl_q <= lvl_q + LVW'(1);
				end
			end
			if (state_q == S_OWT && sts.out_taken && o_q != LAST_SLOT) begin
				o_q <= o_q + SW'(1);
			end
		end
	end

	`PFPS_ASSERT(a_wr_after_drain, (state_q == S_WR) |-> !sts.pipe_busy, "split written while scan busy")
	`PFPS_ASSERT(a_scan_nonempty, (state_q == S_SCAN) |-> !sts.seg_empty, "scan of an empty segment")
	`PFPS_ASSERT(a_stall_cause, $rose(point_stall) |-> $past(point_valid && last_point), "stall without last point")

endmodule

// ===== design/pfps_datapath.sv =====
// Datapath of the farthest point split unit: point store, kept index store,
// cross product pipeline, best point tracking and the output register. Depends on pfps_pkg.
`include "polyline_farthest_point_split_unit_defines.svh"

module pfps_datapath #(
	parameter int MAX_POINTS = 1024,
	parameter int COORD_BITS = 12,
	parameter int LEVELS     = 4,
	parameter int SW         = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	input  pfps_pkg::point_t  point,
	input  pfps_pkg::cmd_t    cmd,
	input  logic [SW-1:0]     kept_addr,
	output pfps_pkg::sts_t    sts,
	output logic              vertex_valid,
	input  logic              vertex_stall,
	output pfps_pkg::vertex_t vertex
);
	import pfps_pkg::*;

	localparam int KEPT = (1 << LEVELS) + 1;
	localparam int IW   = $clog2(MAX_POINTS);
	localparam int CNW  = $clog2(MAX_POINTS + 1);
	localparam int CW   = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
	localparam int PW   = 2 * CW + 2;
	localparam int CXW  = 2 * CW + 3;
	localparam int DW   = 2 * CW + 2;

	logic [2*CW-1:0] store_mem [MAX_POINTS];
	logic [IW-1:0]   kept_mem [KEPT];

	logic [CNW-1:0]  count_q;
	logic [CNW-1:0]  count_m1;
	logic            store_we;
	logic [IW-1:0]   store_raddr;
	logic [2*CW-1:0] store_rd_q;
	logic [IW-1:0]   kept_rd_q;
	logic            kept_we;
	logic [IW-1:0]   kept_wdata;
	logic [CW-1:0]   rdx, rdy;

	logic [IW-1:0]   a_q, b_q, i_q;
	logic [CW-1:0]   ax_q, ay_q;
	logic signed [CW:0] dx_q, dy_q;

	logic            rv_q;
	logic [IW-1:0]   ri_q;
	logic signed [CW:0] px_s1, py_s1;
	logic            v_s1, v_s2, v_s3, v_s4;
	logic [IW-1:0]   idx_s1, idx_s2, idx_s3, idx_s4;
	logic signed [PW-1:0]  m1_s2, m2_s2;
	logic signed [CXW-1:0] c_s3;
	logic signed [CXW-1:0] abs_c;
	logic [DW-1:0]   d_s4;

	logic [DW-1:0]   best_d_q;
	logic [IW-1:0]   best_idx_q;
	logic            found_q;

	vertex_t         vertex_q;
	logic            vertex_valid_q;

	assign rdx      = store_rd_q[CW-1:0];
	assign rdy      = store_rd_q[2*CW-1:CW];
	assign count_m1 = count_q - CNW'(1);
	assign store_we = cmd.pt_write && (count_q < CNW'(MAX_POINTS));
	assign kept_we  = cmd.kept_wr_end || cmd.kept_wr_zero || cmd.kept_wr_split;

	always_comb begin
		if (cmd.kept_wr_end) begin
			kept_wdata = count_m1[IW-1:0];
		end else if (cmd.kept_wr_zero) begin
			kept_wdata = '0;
		end else begin
			kept_wdata = best_idx_q;
		end
	end

	always_comb begin
		unique case (cmd.rd_sel)
			RD_A:    store_raddr = a_q;
			RD_B:    store_raddr = b_q;
			RD_SCAN: store_raddr = i_q;
			RD_OUT:  store_raddr = kept_rd_q;
			default: store_raddr = a_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (store_we) begin
			store_mem[count_q[IW-1:0]] <= {point.point_y[CW-1:0], point.point_x[CW-1:0]};
		end
		store_rd_q <= store_mem[store_raddr];
	end

	always_ff @(posedge clk) begin
		if (kept_we) begin
			kept_mem[kept_addr] <= kept_wdata;
		end
		kept_rd_q <= kept_mem[kept_addr];
	end

	assign abs_c = c_s3[CXW-1] ? -c_s3 : c_s3;

	always_ff @(posedge clk) begin
		if (cmd.a_clear) begin
			a_q <= '0;
		end else if (cmd.a_from_b) begin
			a_q <= b_q;
		end
		if (cmd.b_load) begin
			b_q <= kept_rd_q;
		end
		if (cmd.latch_a) begin
			ax_q <= rdx;
			ay_q <= rdy;
		end
		if (cmd.latch_d) begin
			dx_q <= $signed({1'b0, rdx}) - $signed({1'b0, ax_q});
			dy_q <= $signed({1'b0, rdy}) - $signed({1'b0, ay_q});
			i_q  <= a_q + IW'(1);
		end else if (cmd.scan_issue) begin
			i_q <= i_q + IW'(1);
		end
		ri_q   <= i_q;
		px_s1  <= $signed({1'b0, rdx}) - $signed({1'b0, ax_q});
		py_s1  <= $signed({1'b0, rdy}) - $signed({1'b0, ay_q});
		idx_s1 <= ri_q;
		m1_s2  <= PW'(dx_q) * PW'(py_s1);
		m2_s2  <= PW'(dy_q) * PW'(px_s1);
		idx_s2 <= idx_s1;
		c_s3   <= CXW'(m1_s2) - CXW'(m2_s2);
		idx_s3 <= idx_s2;
		d_s4   <= abs_c[DW-1:0];
		idx_s4 <= idx_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q        <= '0;
			rv_q           <= 1'b0;
			v_s1           <= 1'b0;
			v_s2           <= 1'b0;
			v_s3           <= 1'b0;
			v_s4           <= 1'b0;
			found_q        <= 1'b0;
			best_d_q       <= '0;
			best_idx_q     <= '0;
			vertex_valid_q <= 1'b0;
		end else begin
			if (cmd.cnt_clear) begin
				count_q <= '0;
			end else if (store_we) begin
				count_q <= count_q + CNW'(1);
			end
			rv_q <= cmd.scan_issue;
			v_s1 <= rv_q;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			if (cmd.best_init) begin
				best_idx_q <= a_q;
				found_q    <= 1'b0;
			end else if (v_s4 && (!found_q || d_s4 > best_d_q)) begin
				best_idx_q <= idx_s4;
				best_d_q   <= d_s4;
				found_q    <= 1'b1;
			end
			if (cmd.out_load) begin
				vertex_valid_q <= 1'b1;
			end else if (vertex_valid_q && !vertex_stall) begin
				vertex_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			vertex_q.vertex_x     <= COORD_W'(rdx);
			vertex_q.vertex_y     <= COORD_W'(rdy);
			vertex_q.vertex_index <= INDEX_W'(kept_rd_q);
			vertex_q.last_vertex  <= cmd.out_last;
		end
	end

	assign sts.seg_empty = ({1'b0, b_q} <= ({1'b0, a_q} + (IW + 1)'(1)));
	assign sts.scan_last = (i_q == b_q - IW'(1));
	assign sts.pipe_busy = rv_q || v_s1 || v_s2 || v_s3 || v_s4;
	assign sts.out_taken = vertex_valid_q && !vertex_stall;

	assign vertex_valid = vertex_valid_q;
	assign vertex       = vertex_q;

	`PFPS_ASSERT(a_cand_inside, v_s4 |-> (idx_s4 > a_q && idx_s4 < b_q), "candidate outside segment")
	`PFPS_ASSERT(a_split_inside, cmd.kept_wr_split |-> (best_idx_q == a_q || (best_idx_q > a_q && best_idx_q < b_q)), "split outside segment")
	`PFPS_ASSERT(a_out_cause, $rose(vertex_valid_q) |-> $past(cmd.out_load), "vertex shown without load")

endmodule

// ===== design/polyline_farthest_point_split_unit.sv =====
// Top level of the farthest point split unit (fixed depth polyline simplifier).
// Depends on pfps_pkg, pfps_ctrl and pfps_datapath.
//
// Usage: the point channel (point_valid, point_stall, point) loads the points of
// one open edge, one transaction per point; a point with last_point set closes
// the edge. The block then raises point_stall, splits every kept segment at its
// farthest interior point over LEVELS levels, and sends 2^LEVELS+1 vertices in
// order on the vertex channel (vertex_valid, vertex_stall, vertex), last_vertex
// marking the final one. Points past MAX_POINTS are dropped. Each level is
// paced by the single read port of the point store (one interior point per
// cycle, and a cross product pipeline drain per segment). Each vertex waits
// until it is taken; a stalled vertex holds its value. After the last vertex
// is taken, point_stall drops and the next edge may load. Reset empties the
// point count and returns to loading; no clearing pass is needed.
module polyline_farthest_point_split_unit #(
	parameter int MAX_POINTS = 1024,
	parameter int COORD_BITS = 12,
	parameter int LEVELS     = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              point_valid,
	output logic              point_stall,
	input  pfps_pkg::point_t  point,
	output logic              vertex_valid,
	input  logic              vertex_stall,
	output pfps_pkg::vertex_t vertex
);
	import pfps_pkg::*;

	localparam int KEPT = (1 << LEVELS) + 1;
	localparam int SW   = $clog2(KEPT);

	cmd_t          cmd;
	sts_t          sts;
	logic [SW-1:0] kept_addr;

	pfps_ctrl #(
		.LEVELS (LEVELS),
		.SW     (SW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.point_valid (point_valid),
		.last_point  (point.last_point),
		.point_stall (point_stall),
		.cmd         (cmd),
		.kept_addr   (kept_addr),
		.sts         (sts)
	);

	pfps_datapath #(
		.MAX_POINTS (MAX_POINTS),
		.COORD_BITS (COORD_BITS),
		.LEVELS     (LEVELS),
		.SW         (SW)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.point        (point),
		.cmd          (cmd),
		.kept_addr    (kept_addr),
		.sts          (sts),
		.vertex_valid (vertex_valid),
		.vertex_stall (vertex_stall),
		.vertex       (vertex)
	);

endmodule
